FILE: hdl/rcpw_pkg.sv
// shared types and constants for the rc pwm pulse width capture block
package rcpw_pkg;

	// configuration port geometry
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// register indexes on the configuration port
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MIN_WIDTH    = 3'd0,
		REG_MAX_WIDTH    = 3'd1,
		REG_ROLL_OFFSET  = 3'd2,
		REG_PITCH_OFFSET = 3'd3,
		REG_YAW_OFFSET   = 3'd4
	} reg_index_t;

	// live configuration handed to the capture datapath
	typedef struct packed {
		logic [14:0]        min_width_us;
		logic [14:0]        max_width_us;
		logic signed [15:0] roll_offset;
		logic signed [15:0] pitch_offset;
		logic signed [15:0] yaw_offset;
	} cfg_t;

	// reset values of the configuration registers
	localparam logic [14:0]        MIN_WIDTH_RST    = 15'd800;
	localparam logic [14:0]        MAX_WIDTH_RST    = 15'd2200;
	localparam logic signed [15:0] OFFSET_RST       = 16'sd1500;

	// stick centre added after trimming
	localparam logic [15:0] CENTRE_VALUE = 16'd1500;

	// channels that get centred with a trim
	localparam logic [2:0] ROLL_CHANNEL  = 3'd0;
	localparam logic [2:0] PITCH_CHANNEL = 3'd1;
	localparam logic [2:0] YAW_CHANNEL   = 3'd3;

endpackage

FILE: hdl/rcpw_if.sv
// valid/ready channel interfaces for edge events and capture results

// edge event word
interface rcpw_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  channel;
	logic        level_high;
	logic [31:0] time_us;

	modport source (output valid, channel, level_high, time_us, input ready);
	modport sink   (input valid, channel, level_high, time_us, output ready);
endinterface

// capture result word
interface rcpw_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         out_channel;
	logic               width_in_window;
	logic [31:0]        pulse_width_us;
	logic signed [15:0] channel_value;
	logic signed [15:0] previous_value;

	modport source (output valid, out_channel, width_in_window, pulse_width_us,
		channel_value, previous_value, input ready);
	modport sink   (input valid, out_channel, width_in_window, pulse_width_us,
		channel_value, previous_value, output ready);
endinterface

FILE: hdl/rc_pwm_pulse_width_capture.sv
// RC receiver PWM pulse width capture, top level.
// Takes one edge event word per clock and gives a result word for an accepted falling
// edge, via the input register and then the result register; rising edges, channels past
// NUM_CHANNELS and falls timed before their rise update state as needed and give nothing.
// Throughput is one word per cycle, set by the single pass through the per-channel
// rise-time and held-value registers; a full result register that is not taken holds back
// only words that would produce a result. Timestamps use their low TIME_BITS bits.
// Configuration writes are meant for idle periods only.
module rc_pwm_pulse_width_capture #(
	parameter int NUM_CHANNELS = 6,
	parameter int TIME_BITS    = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rcpw_in_if.sink                           in_ch,
	rcpw_out_if.source                        out_ch,
	input  logic                              cfg_wr_en,
	input  logic [rcpw_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [rcpw_pkg::CFG_DATA_W-1:0]   cfg_data
);

	rcpw_pkg::cfg_t cfg;

	// configuration registers
	rcpw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// capture datapath
	rcpw_capture #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.TIME_BITS    (TIME_BITS)
	) u_capture (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

FILE: hdl/rcpw_cfg.sv
// configuration register file for the capture window and trims
module rcpw_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [rcpw_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [rcpw_pkg::CFG_DATA_W-1:0]   cfg_data,
	output rcpw_pkg::cfg_t                    cfg
);

	rcpw_pkg::cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_width_us <= rcpw_pkg::MIN_WIDTH_RST;
			cfg_q.max_width_us <= rcpw_pkg::MAX_WIDTH_RST;
			cfg_q.roll_offset  <= rcpw_pkg::OFFSET_RST;
			cfg_q.pitch_offset <= rcpw_pkg::OFFSET_RST;
			cfg_q.yaw_offset   <= rcpw_pkg::OFFSET_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rcpw_pkg::REG_MIN_WIDTH:    cfg_q.min_width_us <= cfg_data[14:0];
				rcpw_pkg::REG_MAX_WIDTH:    cfg_q.max_width_us <= cfg_data[14:0];
				rcpw_pkg::REG_ROLL_OFFSET:  cfg_q.roll_offset  <= cfg_data;
				rcpw_pkg::REG_PITCH_OFFSET: cfg_q.pitch_offset <= cfg_data;
				rcpw_pkg::REG_YAW_OFFSET:   cfg_q.yaw_offset   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/rcpw_capture.sv
// input register, per-channel rise/held state, width check and result register
module rcpw_capture #(
	parameter int NUM_CHANNELS = 6,
	parameter int TIME_BITS    = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rcpw_pkg::cfg_t cfg,
	rcpw_in_if.sink        in_ch,
	rcpw_out_if.source     out_ch
);

	localparam int          CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [3:0]  CH_LIMIT = 4'(NUM_CHANNELS);

	// input stage
	logic                 valid_s1;
	logic [2:0]           channel_s1;
	logic                 level_s1;
	logic [TIME_BITS-1:0] time_s1;

	// per-channel state
	logic [TIME_BITS-1:0] rise_q [NUM_CHANNELS];
	logic [15:0]          held_q [NUM_CHANNELS];

	// result register
	logic                 out_valid_q;
	logic [2:0]           out_channel_q;
	logic                 out_win_q;
	logic [31:0]          out_width_q;
	logic [15:0]          out_value_q;
	logic [15:0]          out_prev_q;

	logic                 ch_ok;
	logic [CH_IDX_W-1:0]  idx;
	logic [TIME_BITS-1:0] rise_t;
	logic [TIME_BITS-1:0] width;
	logic                 fall_ok;
	logic                 in_win;
	logic                 centred;
	logic [15:0]          trim;
	logic [15:0]          prev_val;
	logic [15:0]          next_val;
	logic                 produce;
	logic                 out_free;
	logic                 advance;
	logic                 in_take;

	// look up the channel and measure the pulse
	always_comb begin
		ch_ok   = ({1'b0, channel_s1} < CH_LIMIT);
		idx     = channel_s1[CH_IDX_W-1:0];
		rise_t  = rise_q[idx];
		prev_val = held_q[idx];
		fall_ok = (time_s1 >= rise_t);
		width   = time_s1 - rise_t;
		in_win  = (width > TIME_BITS'(cfg.min_width_us)) &&
			(width < TIME_BITS'(cfg.max_width_us));
	end

	// trim selection for the centred sticks
	always_comb begin
		centred = 1'b1;
		case (channel_s1)
			rcpw_pkg::ROLL_CHANNEL:  trim = cfg.roll_offset;
			rcpw_pkg::PITCH_CHANNEL: trim = cfg.pitch_offset;
			rcpw_pkg::YAW_CHANNEL:   trim = cfg.yaw_offset;
			default: begin
				trim    = '0;
				centred = 1'b0;
			end
		endcase
	end

	// new held value, 16-bit wrapping
	always_comb begin
		next_val = prev_val;
		if (centred) begin
			if (in_win) begin
				next_val = width[15:0] - trim + rcpw_pkg::CENTRE_VALUE;
			end else begin
				next_val = rcpw_pkg::CENTRE_VALUE;
			end
		end else if (in_win) begin
			next_val = width[15:0];
		end
	end

	// flow control: only result-bearing words wait for the output
	assign produce  = valid_s1 && ch_ok && !level_s1 && fall_ok;
	assign out_free = !out_valid_q || out_ch.ready;
	assign advance  = valid_s1 && (!produce || out_free);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_take  = in_ch.valid && in_ch.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			channel_s1 <= in_ch.channel;
			level_s1   <= in_ch.level_high;
			time_s1    <= in_ch.time_us[TIME_BITS-1:0];
		end
	end

	// channel state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				rise_q[i] <= '0;
				held_q[i] <= '0;
			end
		end else if (advance && ch_ok) begin
			if (level_s1) begin
				rise_q[idx] <= time_s1;
			end else if (produce) begin
				held_q[idx] <= next_val;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= produce && advance;
		end
	end

	always_ff @(posedge clk) begin
		if (produce && advance) begin
			out_channel_q <= channel_s1;
			out_win_q     <= in_win;
			out_width_q   <= 32'(width);
			out_value_q   <= next_val;
			out_prev_q    <= prev_val;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.out_channel     = out_channel_q;
	assign out_ch.width_in_window = out_win_q;
	assign out_ch.pulse_width_us  = out_width_q;
	assign out_ch.channel_value   = out_value_q;
	assign out_ch.previous_value  = out_prev_q;

endmodule
